@@ rtl/core/sgm_pkg.sv @@
// Shared types and constants for the Sobel gradient magnitude block.
package sgm_pkg;

  localparam int MaxWidthDef  = 1024;
  localparam int MaxHeightDef = 1024;

  localparam int PixW     = 8;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 11;

  localparam logic [CfgDataW-1:0] FrameWidthRst  = 11'd1024;
  localparam logic [CfgDataW-1:0] FrameHeightRst = 11'd1024;

  // Integer square root: one result bit per step, MSB first.
  localparam int RootSteps = 8;
  localparam int RootIdxW  = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_GRAD,
    ST_SQUARE,
    ST_ROOT,
    ST_PUSH
  } state_e;

  typedef struct packed {
    logic                cfg_write;
    logic                accept;
    logic                update;
    logic                grad;
    logic                square;
    logic                root_step;
    logic [RootIdxW-1:0] root_idx;
    logic                push;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic emit;
    logic out_free;
  } status_t;

endpackage

@@ rtl/core/sgm_ctrl.sv @@
// Sequencing state machine for the Sobel gradient magnitude block.
module sgm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             cfg_valid_i,
  input  sgm_pkg::status_t status_i,
  output sgm_pkg::cmd_t    cmd_o,
  output logic             in_stall_o,
  output logic             cfg_ready_o
);
  import sgm_pkg::*;

  state_e              state_q, state_d;
  logic [RootIdxW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !cfg_valid_i && !status_i.skip) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_d = status_i.emit ? ST_GRAD : ST_IDLE;
      end
      ST_GRAD: begin
        state_d = ST_SQUARE;
      end
      ST_SQUARE: begin
        state_d = ST_ROOT;
        cnt_d   = RootIdxW'(RootSteps - 1);
      end
      ST_ROOT: begin
        if (cnt_q == '0) state_d = ST_PUSH;
        else cnt_d = cnt_q - 1'b1;
      end
      ST_PUSH: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    cfg_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        // a register write goes first; the item is held off while it is taken
        in_stall_o      = cfg_valid_i;
        cfg_ready_o     = 1'b1;
        cmd_o.accept    = in_valid_i && !cfg_valid_i;
        cmd_o.cfg_write = cfg_valid_i;
      end
      ST_UPDATE: cmd_o.update = 1'b1;
      ST_GRAD:   cmd_o.grad   = 1'b1;
      ST_SQUARE: cmd_o.square = 1'b1;
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        cmd_o.root_idx  = cnt_q;
      end
      ST_PUSH:   cmd_o.push   = status_i.out_free;
      default:   cmd_o        = '0;
    endcase
  end

endmodule

@@ rtl/core/sgm_datapath.sv @@
// Line store, window, position counters, gradient, root unit and result register.
module sgm_datapath #(
  parameter int MAX_WIDTH  = sgm_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = sgm_pkg::MaxHeightDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sgm_pkg::cmd_t                cmd_i,
  output sgm_pkg::status_t             status_o,
  input  logic [sgm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sgm_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         op_i,
  input  logic [sgm_pkg::PixW-1:0]     pixel_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [sgm_pkg::PixW-1:0]     magnitude_o,
  output logic                         frame_end_o
);
  import sgm_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // configuration
  logic [CfgDataW-1:0] width_q, height_q;
  logic [CW-1:0]       w_eff;
  logic [RW-1:0]       h_eff;
  logic                restart;

  always_comb begin
    if (width_q == '0) w_eff = CW'(1);
    else if (32'(width_q) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(width_q);
    if (height_q == '0) h_eff = RW'(1);
    else if (32'(height_q) > MAX_HEIGHT) h_eff = RW'(MAX_HEIGHT);
    else h_eff = RW'(height_q);
  end

  assign restart = cmd_i.cfg_write &&
                   (cfg_index_i == CFG_FRAME_WIDTH || cfg_index_i == CFG_FRAME_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= FrameWidthRst;
      height_q <= FrameHeightRst;
    end else if (cmd_i.cfg_write) begin
      if (cfg_index_i == CFG_FRAME_WIDTH)  width_q  <= cfg_data_i;
      if (cfg_index_i == CFG_FRAME_HEIGHT) height_q <= cfg_data_i;
    end
  end

  // position counters
  logic [CW-1:0] in_col_q, out_col_q;
  logic [RW-1:0] in_row_q, out_row_q;
  logic          pixel_phase;

  assign pixel_phase   = in_row_q < h_eff;
  assign status_o.skip = op_i && pixel_phase;
  assign status_o.emit = (in_row_q >= RW'(2)) || (in_row_q == RW'(1) && in_col_q != '0);

  // neighbor masks for the result position
  logic top_ok, bot_ok, left_ok, right_ok, last;
  assign top_ok   = out_row_q != '0;
  assign bot_ok   = out_row_q != (h_eff - 1'b1);
  assign left_ok  = out_col_q != '0;
  assign right_ok = out_col_q != (w_eff - 1'b1);
  assign last     = !bot_ok && !right_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (restart) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (cmd_i.update) begin
      if (in_col_q == w_eff - 1'b1) begin
        in_col_q <= '0;
        in_row_q <= in_row_q + 1'b1;
      end else begin
        in_col_q <= in_col_q + 1'b1;
      end
    end else if (cmd_i.grad) begin
      if (last) begin
        in_col_q  <= '0;
        in_row_q  <= '0;
        out_col_q <= '0;
        out_row_q <= '0;
      end else if (!right_ok) begin
        out_col_q <= '0;
        out_row_q <= out_row_q + 1'b1;
      end else begin
        out_col_q <= out_col_q + 1'b1;
      end
    end
  end

  // line store: one word per column, low byte = older row, high byte = newer row
  logic [2*PixW-1:0] mem [MAX_WIDTH];
  logic [2*PixW-1:0] rd_q;
  logic [PixW-1:0]   pix_q;
  logic [AW-1:0]     addr;

  assign addr = in_col_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) rd_q <= mem[addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) mem[addr] <= {pix_q, rd_q[2*PixW-1:PixW]};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) pix_q <= pixel_phase ? pixel_i : '0;
  end

  // 3x3 window, row 0 on top, column 2 newest
  logic [PixW-1:0] win_q [3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) win_q[r][c] <= '0;
      end
    end else if (restart) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) win_q[r][c] <= '0;
      end
    end else if (cmd_i.update) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= rd_q[PixW-1:0];
      win_q[1][2] <= rd_q[2*PixW-1:PixW];
      win_q[2][2] <= pix_q;
    end
  end

  // gradients
  logic signed [11:0] v [3][3];
  logic signed [11:0] gx, gy, gx_q, gy_q;
  logic               last_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        v[r][c] = $signed({4'b0, win_q[r][c]});
      end
    end
    if (!top_ok) begin
      for (int c = 0; c < 3; c++) v[0][c] = '0;
    end
    if (!bot_ok) begin
      for (int c = 0; c < 3; c++) v[2][c] = '0;
    end
    if (!left_ok) begin
      for (int r = 0; r < 3; r++) v[r][0] = '0;
    end
    if (!right_ok) begin
      for (int r = 0; r < 3; r++) v[r][2] = '0;
    end
    gx = (v[0][2] - v[0][0]) + ((v[1][2] - v[1][0]) <<< 1) + (v[2][2] - v[2][0]);
    gy = (v[0][0] - v[2][0]) + ((v[0][1] - v[2][1]) <<< 1) + (v[0][2] - v[2][2]);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.grad) begin
      gx_q   <= gx;
      gy_q   <= gy;
      last_q <= last;
    end
  end

  // energy and saturation
  logic signed [23:0] sqx, sqy;
  logic [24:0]        energy;
  logic [15:0]        energy_q;
  logic               sat_q;

  assign sqx    = gx_q * gx_q;
  assign sqy    = gy_q * gy_q;
  assign energy = {1'b0, sqx} + {1'b0, sqy};

  always_ff @(posedge clk_i) begin
    if (cmd_i.square) begin
      energy_q <= energy[15:0];
      sat_q    <= |energy[24:16];
    end
  end

  // integer square root, one bit per step
  logic [PixW-1:0]   root_q, trial;
  logic [2*PixW-1:0] trial_sq;

  always_comb begin
    trial    = root_q | (PixW'(1) << cmd_i.root_idx);
    trial_sq = trial * trial;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.square) root_q <= '0;
    else if (cmd_i.root_step && trial_sq <= energy_q) root_q <= trial;
  end

  // result register
  logic            out_valid_q;
  logic [PixW-1:0] mag_q;
  logic            end_q;

  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mag_q <= sat_q ? '1 : root_q;
      end_q <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign magnitude_o = mag_q;
  assign frame_end_o = end_q;

endmodule

@@ rtl/core/sobel_gradient_magnitude.sv @@
// Top level of the streaming 3x3 Sobel gradient magnitude block.
//
// channel   direction  handshake            payload
// in        sink       in_valid_i/in_stall_o  op_i, pixel_i
// out       source     out_valid_o/out_stall_i magnitude_o, frame_end_o
// cfg       sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// An item that yields a result passes accept, line store update, gradient,
// square, 8 root steps and push, plus any wait for the result register; the
// bit-serial square root makes up most of them. An item with no result passes
// accept and line store update only; a drain item that arrives while pixels
// are still expected ends at accept. Register writes are taken only between
// items and hold off an item offered in the same cycle. Reset clears control,
// counters and window; the line store is not cleared. A finished result waits
// in the output register under out_stall_i while the next item is worked on.
module sobel_gradient_magnitude #(
  parameter int MAX_WIDTH  = sgm_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = sgm_pkg::MaxHeightDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // pixel items
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         op_i,
  input  logic [sgm_pkg::PixW-1:0]     pixel_i,
  // result items
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [sgm_pkg::PixW-1:0]     magnitude_o,
  output logic                         frame_end_o,
  // register writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sgm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sgm_pkg::CfgDataW-1:0] cfg_data_i
);
  import sgm_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Controller: sequences each item through the shared datapath.
  sgm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cfg_valid_i(cfg_valid_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o),
    .cfg_ready_o(cfg_ready_o)
  );

  // Datapath: line store, window, counters, gradient, root and result register.
  sgm_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .op_i       (op_i),
    .pixel_i    (pixel_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .magnitude_o(magnitude_o),
    .frame_end_o(frame_end_o)
  );

endmodule
